[rtl/assert_macros.svh]
// Assertion wrappers shared by the oscillator RTL.
// Needs clk and rst_n in the scope of each use; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// property checked every edge outside reset
`define IWO_CHECK(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// cause in this cycle, effect in the next
`define IWO_CHECK_NEXT(name, cause, effect, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cause) |=> (effect)) \
    else $error(msg);
`else
`define IWO_CHECK(name, prop, msg)
`define IWO_CHECK_NEXT(name, cause, effect, msg)
`endif
`endif

[rtl/iwo_pkg.sv]
// Shared types and constants for the interpolated wavetable oscillator.
// No dependencies; imported by the front end, the back end and the top-level module.
package iwo_pkg;

  localparam int SAMPLES_PER_CYCLE = 128;
  localparam int ROW_COUNT_DEF     = 256;
  localparam longint unsigned TICK_RATE_HZ = 64'd8_000_000;
  localparam int F0_MIN_HZ = 250;
  localparam int F0_MAX_HZ = 4200;

  localparam int COL_W    = $clog2(SAMPLES_PER_CYCLE);
  localparam int PERIOD_W = 20;
  localparam logic [PERIOD_W-1:0] PERIOD_MAX = '1;

  // period = floor((2N + D) / 2D), N = rate*16, D = q*S
  localparam longint unsigned PERIOD_NUM2   = 64'd32 * TICK_RATE_HZ;
  localparam longint unsigned RESET_FREQ_Q4 = 64'd1760;
  localparam logic [PERIOD_W-1:0] RESET_PERIOD = PERIOD_W'(
    (PERIOD_NUM2 + RESET_FREQ_Q4 * SAMPLES_PER_CYCLE) /
    (64'd2 * RESET_FREQ_Q4 * SAMPLES_PER_CYCLE));

  // period divider operand widths
  localparam int DIV_W = 32;
  localparam int DSR_W = 16 + $clog2(2 * SAMPLES_PER_CYCLE);

  // row position mapping, in Q4 Hz
  localparam int POS_LO = 16 * F0_MIN_HZ;

  // pos = floor((q - lo) * (rows-1) * 16 / (F0_MAX - F0_MIN)); the numerator stays
  // below 2^POS_NUM_W, so a rounded-up reciprocal with this shift is exact
  localparam int POS_DEN   = F0_MAX_HZ - F0_MIN_HZ;
  localparam int POS_NUM_W = 28;
  localparam int POS_SHIFT = POS_NUM_W + $clog2(POS_DEN);
  localparam int POS_RCP_W = POS_NUM_W + 1;
  localparam logic [POS_RCP_W-1:0] POS_RCP = POS_RCP_W'(
    ((64'd1 << POS_SHIFT) + 64'(POS_DEN) - 64'd1) / 64'(POS_DEN));

  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_FREQ  = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] freq_q4;
    logic [7:0]  table_row;
    logic [6:0]  table_col;
    logic [7:0]  table_value;
  } iwo_in_t;

  typedef struct packed {
    logic [7:0] sample;
    logic [6:0] phase;
  } iwo_out_t;

  // classified operation held in the front queue
  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] freq_q4;
    logic [7:0]  table_row;
    logic [6:0]  table_col;
    logic [7:0]  table_value;
  } iwo_op_t;

endpackage

[rtl/iwo_ram.sv]
// Generic single-write, dual-read RAM with registered read data.
// No dependencies.
module iwo_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

[rtl/iwo_div.sv]
// Restoring divider, one quotient bit per cycle; divisor zero gives all ones.
// Depends on nothing; used by the back end for the sample period.
module iwo_div #(
  parameter int DVD_W = 32,
  parameter int DSR_W = 24
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DSR_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] quo_r;
  logic [DSR_W-1:0] rem_r;
  logic [DSR_W-1:0] dsr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [DSR_W:0]   rem_sh;
  logic [DSR_W:0]   rem_diff;
  logic             ge;

  assign rem_sh   = {rem_r, quo_r[DVD_W-1]};
  assign ge       = rem_sh >= {1'b0, dsr_r};
  assign rem_diff = rem_sh - {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DVD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DVD_W-2:0], ge};
      rem_r <= ge ? rem_diff[DSR_W-1:0] : rem_sh[DSR_W-1:0];
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

[rtl/iwo_front.sv]
// Front end: takes input transactions, drops no-op ones, queues the rest.
// Depends on iwo_pkg and assert_macros.svh.
`include "assert_macros.svh"
module iwo_front #(
  parameter int ROW_COUNT = iwo_pkg::ROW_COUNT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  iwo_pkg::iwo_in_t  in_data,
  output logic              q_valid,
  output iwo_pkg::iwo_op_t  q_op,
  input  logic              q_pop
);
  import iwo_pkg::*;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  iwo_op_t           q_mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] q_cnt_r;
  logic [QCNT_W-1:0] q_cnt_nxt;

  logic    in_acc;
  logic    row_ok;
  logic    col_ok;
  logic    keep;
  logic    push;
  iwo_op_t op_nxt;

  assign in_stall = q_cnt_r == QCNT_W'(QDEPTH);
  assign in_acc   = in_valid && !in_stall;

  // out-of-range writes and the unused command code cause nothing
  assign row_ok = 32'(in_data.table_row) < ROW_COUNT;
  assign col_ok = 32'(in_data.table_col) < SAMPLES_PER_CYCLE;
  assign keep   = (in_data.command == CMD_TICK) || (in_data.command == CMD_FREQ) ||
                  ((in_data.command == CMD_WRITE) && row_ok && col_ok);
  assign push   = in_acc && keep;

  always_comb begin
    op_nxt.cmd         = in_data.command;
    op_nxt.freq_q4     = in_data.freq_q4;
    op_nxt.table_row   = in_data.table_row;
    op_nxt.table_col   = in_data.table_col;
    op_nxt.table_value = in_data.table_value;
  end

  always_comb begin
    case ({push, q_pop})
      2'b10:   q_cnt_nxt = q_cnt_r + QCNT_W'(1);
      2'b01:   q_cnt_nxt = q_cnt_r - QCNT_W'(1);
      default: q_cnt_nxt = q_cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      q_cnt_r  <= '0;
    end else begin
      q_cnt_r <= q_cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (q_pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= op_nxt;
    end
  end

  assign q_valid = q_cnt_r != '0;
  assign q_op    = q_mem_r[rd_ptr_r];

  `IWO_CHECK(a_q_bound, q_cnt_r <= QCNT_W'(QDEPTH), "queue count above depth")
  `IWO_CHECK(a_pop_nonempty, q_pop |-> (q_cnt_r != '0), "pop from empty queue")
  `IWO_CHECK_NEXT(a_drop_noq, in_acc && !keep && !q_pop, q_cnt_r == $past(q_cnt_r),
    "dropped transaction changed queue")

endmodule

[rtl/iwo_back.sv]
// Back end: tick timer, table writes, frequency setup (period divider, row position
// by reciprocal multiply), interpolated readout and the output register.
// Depends on iwo_pkg, iwo_ram, iwo_div and assert_macros.svh.
`include "assert_macros.svh"
module iwo_back #(
  parameter int ROW_COUNT = iwo_pkg::ROW_COUNT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  iwo_pkg::iwo_op_t  q_op,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output iwo_pkg::iwo_out_t out_data
);
  import iwo_pkg::*;

  localparam int DEPTH      = ROW_COUNT * SAMPLES_PER_CYCLE;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int ROW_TOP    = (ROW_COUNT - 2) * 256 + 255;
  localparam int POS_PROD_W = POS_NUM_W + POS_RCP_W;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_BLEND  = 3'd1;
  localparam logic [2:0] ST_FSETUP = 3'd2;
  localparam logic [2:0] ST_PDIV   = 3'd3;

  logic [2:0]          state_r,      state_nxt;
  logic [PERIOD_W-1:0] tick_count_r, tick_count_nxt;
  logic [PERIOD_W-1:0] period_r,     period_nxt;
  logic [7:0]          base_row_r,   base_row_nxt;
  logic [7:0]          weight_r,     weight_nxt;
  logic [COL_W-1:0]    cursor_r,     cursor_nxt;
  logic                out_valid_r,  out_valid_nxt;
  iwo_out_t            out_data_r;
  logic [15:0]         freq_r;
  logic [POS_NUM_W-1:0] pos_num_r;
  logic [COL_W-1:0]    phase_r;

  logic [PERIOD_W-1:0] cnt_inc;
  logic                fire;
  logic                is_tick;
  logic                is_freq;
  logic                is_write;
  logic                out_free;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic              ram_re;
  logic [ADDR_W-1:0] raddr_a;
  logic [ADDR_W-1:0] raddr_b;
  logic [7:0]        rdata_a;
  logic [7:0]        rdata_b;

  logic             div_start;
  logic [DIV_W-1:0] div_dvd;
  logic [DSR_W-1:0] div_dsr;
  logic             div_done;
  logic [DIV_W-1:0] div_quo;

  logic [POS_NUM_W-1:0]  pos_num_nxt;
  logic [POS_PROD_W-1:0] pos_prod;
  logic [15:0]           pos_quo;
  logic [15:0]           pos_clamp;

  logic [16:0] mix;

  assign q_pop    = (state_r == ST_IDLE) && q_valid;
  assign is_tick  = q_op.cmd == CMD_TICK;
  assign is_freq  = q_op.cmd == CMD_FREQ;
  assign is_write = q_op.cmd == CMD_WRITE;

  assign cnt_inc = tick_count_r + PERIOD_W'(1);
  assign fire    = cnt_inc >= period_r;

  // table access
  assign ram_we    = q_pop && is_write;
  assign ram_waddr = ADDR_W'(q_op.table_row) * ADDR_W'(SAMPLES_PER_CYCLE) +
                     ADDR_W'(q_op.table_col);
  assign ram_re    = q_pop && is_tick && fire;
  assign raddr_a   = ADDR_W'(base_row_r) * ADDR_W'(SAMPLES_PER_CYCLE) + ADDR_W'(cursor_r);
  assign raddr_b   = raddr_a + ADDR_W'(SAMPLES_PER_CYCLE);

  iwo_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_table (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (q_op.table_value),
    .re      (ram_re),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  // row position numerator: (q - lo) * (rows-1) * 16, zero at or below lo
  assign pos_num_nxt = (freq_r > 16'(POS_LO)) ?
                       POS_NUM_W'(freq_r - 16'(POS_LO)) * POS_NUM_W'(16 * (ROW_COUNT - 1)) :
                       '0;

  // divide by the constant span through the rounded-up reciprocal
  assign pos_prod  = POS_PROD_W'(pos_num_r) * POS_PROD_W'(POS_RCP);
  assign pos_quo   = pos_prod[POS_SHIFT +: 16];
  assign pos_clamp = (pos_quo > 16'(ROW_TOP)) ? 16'(ROW_TOP) : pos_quo;

  // period divide; zero divisor saturates
  assign div_start = state_r == ST_FSETUP;
  assign div_dvd   = DIV_W'(PERIOD_NUM2) + DIV_W'(freq_r) * DIV_W'(SAMPLES_PER_CYCLE);
  assign div_dsr   = DSR_W'(freq_r) * DSR_W'(2 * SAMPLES_PER_CYCLE);

  iwo_div #(
    .DVD_W (DIV_W),
    .DSR_W (DSR_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign mix = 17'(rdata_a) * 17'(9'd256 - {1'b0, weight_r}) +
               17'(rdata_b) * 17'(weight_r);

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt      = state_r;
    tick_count_nxt = tick_count_r;
    period_nxt     = period_r;
    base_row_nxt   = base_row_r;
    weight_nxt     = weight_r;
    cursor_nxt     = cursor_r;
    out_valid_nxt  = out_valid_r && out_stall;
    case (state_r)
      ST_IDLE: begin
        if (q_pop && is_tick) begin
          if (fire) begin
            tick_count_nxt = '0;
            cursor_nxt     = (cursor_r == COL_W'(SAMPLES_PER_CYCLE - 1)) ?
                             '0 : cursor_r + COL_W'(1);
            state_nxt      = ST_BLEND;
          end else begin
            tick_count_nxt = cnt_inc;
          end
        end else if (q_pop && is_freq) begin
          state_nxt = ST_FSETUP;
        end
      end
      ST_BLEND: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_FSETUP: begin
        state_nxt = ST_PDIV;
      end
      ST_PDIV: begin
        if (div_done) begin
          period_nxt   = (|div_quo[DIV_W-1:PERIOD_W]) ? PERIOD_MAX : div_quo[PERIOD_W-1:0];
          base_row_nxt = pos_clamp[15:8];
          weight_nxt   = pos_clamp[7:0];
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      tick_count_r <= '0;
      period_r     <= RESET_PERIOD;
      base_row_r   <= '0;
      weight_r     <= '0;
      cursor_r     <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      tick_count_r <= tick_count_nxt;
      period_r     <= period_nxt;
      base_row_r   <= base_row_nxt;
      weight_r     <= weight_nxt;
      cursor_r     <= cursor_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && is_freq) begin
      freq_r <= q_op.freq_q4;
    end
    if (state_r == ST_FSETUP) begin
      pos_num_r <= pos_num_nxt;
    end
    if (ram_re) begin
      phase_r <= cursor_r;
    end
    if ((state_r == ST_BLEND) && out_free) begin
      out_data_r.sample <= mix[15:8];
      out_data_r.phase  <= phase_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `IWO_CHECK_NEXT(a_fire_blend, ram_re, state_r == ST_BLEND, "firing tick skipped readout")
  `IWO_CHECK(a_div_state, div_done |-> (state_r == ST_PDIV), "divider result outside setup")
  `IWO_CHECK(a_row_pair, 32'(base_row_r) <= ROW_COUNT - 2, "upper blend row beyond table")
  `IWO_CHECK_NEXT(a_blend_hold, (state_r == ST_BLEND) && out_valid_r && out_stall,
    state_r == ST_BLEND, "blend left while output held")

endmodule

[rtl/interpolated_wavetable_oscillator_unit.sv]
// Interpolated wavetable oscillator. A tick that reaches the period gives a sample
// via a dual-port table read, then blend and output register; ticks that do not
// fire retire at 1 per cycle while the back end is idle. A firing tick holds the
// back end for both steps, and set frequency for one 32-step period divide.
// Reset (rst_n low, synchronous) clears timer, cursor, row and weight, loads the
// 110 Hz period; the table keeps whatever it held and needs no clearing pass.
module interpolated_wavetable_oscillator_unit #(
  parameter int ROW_COUNT = iwo_pkg::ROW_COUNT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  iwo_pkg::iwo_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output iwo_pkg::iwo_out_t out_data
);
  import iwo_pkg::*;

  // Front and back are decoupled by a four-entry queue: the front keeps taking
  // transactions while the back sits in a divide or waits on a stalled output.
  logic    q_valid;
  iwo_op_t q_op;
  logic    q_pop;

  // Front: handshake, drops the unused command and out-of-range table writes.
  iwo_front #(
    .ROW_COUNT (ROW_COUNT)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_op     (q_op),
    .q_pop    (q_pop)
  );

  // Back: executes one queued operation at a time in arrival order, so table
  // writes and readouts never reorder. The output register lets the back take
  // further non-firing ticks while a sample waits to be taken.
  iwo_back #(
    .ROW_COUNT (ROW_COUNT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_op      (q_op),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

[sim/tb_top.sv]
// Self-checking testbench for interpolated_wavetable_oscillator_unit.
// Tracks table, timer, period and blend position to predict every emitted sample.
// Depends on iwo_pkg and the oscillator RTL only.
module tb_top;
  import iwo_pkg::*;

  localparam int RESET_CYCLES     = 7;
  localparam int RANDOM_ITEMS     = 1100;
  localparam int DRAIN_CYCLES     = 150;  // covers a set-frequency divide plus the blend path
  localparam int CYCLE_LIMIT      = 600000;
  localparam int TABLE_DEPTH      = ROW_COUNT_DEF * SAMPLES_PER_CYCLE;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic     clk      = 1'b0;
  logic     rst_n    = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  iwo_in_t  in_data  = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  iwo_out_t out_data;

  interpolated_wavetable_oscillator_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Oscillator predictor: shadow copy of the table and the tone state.
  // ---------------------------------------------------------------------------
  logic [7:0]  wave_mem [TABLE_DEPTH];
  bit          written  [TABLE_DEPTH];  // never read an entry that was not loaded
  logic [19:0] timer;
  logic [19:0] period;
  logic [7:0]  row_sel;
  logic [7:0]  blend_w;
  logic [6:0]  cursor_pos;

  iwo_out_t expected_samples [$];

  int err_count     = 0;
  int item_count    = 0;
  int sample_count  = 0;  // samples predicted
  int checked_count = 0;  // samples received and compared
  int freq_count    = 0;
  int write_count   = 0;
  int cycle_count   = 0;

  // rounded ticks per sample; zero frequency parks at the slowest period
  function automatic logic [19:0] period_from_freq(input logic [15:0] q);
    longint unsigned den, p;
    if (q == 16'd0) return PERIOD_MAX;
    den = longint'(q) * SAMPLES_PER_CYCLE;
    p = (64'd32 * TICK_RATE_HZ + den) / (64'd2 * den);
    if (p > longint'(PERIOD_MAX)) p = longint'(PERIOD_MAX);
    return p[19:0];
  endfunction

  // 8.8 row position: row in the upper byte, blend weight in the lower
  function automatic logic [15:0] row_position(input logic [15:0] q);
    longint unsigned lo, span, top, pos;
    lo   = 16 * F0_MIN_HZ;
    span = 16 * (F0_MAX_HZ - F0_MIN_HZ);
    top  = (ROW_COUNT_DEF - 2) * 256 + 255;
    pos  = 0;
    if (longint'(q) > lo) pos = ((longint'(q) - lo) * (ROW_COUNT_DEF - 1) * 256) / span;
    if (pos > top) pos = top;
    return pos[15:0];
  endfunction

  // Applies one accepted transaction to the shadow state; a firing tick
  // queues the blended sample it must produce.
  task automatic predict_oscillator(input iwo_in_t item);
    logic [15:0] pos;
    logic [14:0] ia, ib;
    int unsigned mix;
    iwo_out_t res;
    case (item.command)
      CMD_FREQ: begin
        period  = period_from_freq(item.freq_q4);
        pos     = row_position(item.freq_q4);
        row_sel = pos[15:8];
        blend_w = pos[7:0];
        freq_count++;
      end
      CMD_WRITE: begin
        wave_mem[{item.table_row, item.table_col}] = item.table_value;
        written[{item.table_row, item.table_col}]  = 1'b1;
        write_count++;
      end
      CMD_TICK: begin
        timer = timer + 20'd1;
        if (timer >= period) begin
          timer = '0;
          ia  = {row_sel, cursor_pos};
          ib  = ia + 15'd128;
          mix = int'(wave_mem[ia]) * (256 - int'(blend_w)) + int'(wave_mem[ib]) * int'(blend_w);
          res.sample = 8'(mix >> 8);
          res.phase  = cursor_pos;
          expected_samples.push_back(res);
          cursor_pos = cursor_pos + 7'd1;
          sample_count++;
        end
      end
      default: ;  // unused command: no effect
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Sender: bursts of random length separated by random idle gaps.
  // ---------------------------------------------------------------------------
  int burst_left = 0;

  function automatic iwo_in_t random_item(input logic [1:0] cmd);
    iwo_in_t it;
    it.command     = cmd;
    it.freq_q4     = 16'($urandom);
    it.table_row   = 8'($urandom);
    it.table_col   = 7'($urandom);
    it.table_value = 8'($urandom);
    return it;
  endfunction

  // Called at a rising edge; returns at the edge where the transaction is taken.
  task automatic send_item(input iwo_in_t item);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    predict_oscillator(item);
    item_count++;
  endtask

  task automatic send_write(input logic [7:0] row, input logic [6:0] col,
                            input logic [7:0] value);
    iwo_in_t it;
    it = random_item(CMD_WRITE);
    it.table_row   = row;
    it.table_col   = col;
    it.table_value = value;
    send_item(it);
  endtask

  task automatic send_freq(input logic [15:0] q);
    iwo_in_t it;
    it = random_item(CMD_FREQ);
    it.freq_q4 = q;
    send_item(it);
  endtask

  // A tick that will fire reads two rows at the cursor; load them first if needed.
  task automatic send_tick();
    logic [14:0] ia, ib;
    if (timer + 20'd1 >= period) begin
      ia = {row_sel, cursor_pos};
      ib = ia + 15'd128;
      if (!written[ia]) send_write(ia[14:7], ia[6:0], 8'($urandom));
      if (!written[ib]) send_write(ib[14:7], ib[6:0], 8'($urandom));
    end
    send_item(random_item(CMD_TICK));
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: stall pattern switches between quiet, light, heavy and periodic.
  // ---------------------------------------------------------------------------
  int stall_mode = 0;
  int stall_left = 0;

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 200);
    end
    stall_left--;
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 3) == 0);
      2:       out_stall <= ($urandom_range(0, 9) < 7);
      default: out_stall <= ((stall_left % 16) < 10);
    endcase
  end

  // ---------------------------------------------------------------------------
  // Result checker: every accepted sample against the oldest prediction.
  // ---------------------------------------------------------------------------
  iwo_out_t want;

  task automatic report_mismatch(input string msg);
    $display("[%0d] mismatch: %s", cycle_count, msg);
    err_count++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_samples.size() == 0) begin
        report_mismatch($sformatf("unexpected sample %0d phase %0d",
                                  out_data.sample, out_data.phase));
      end else begin
        want = expected_samples.pop_front();
        if (out_data.sample !== want.sample)
          report_mismatch($sformatf("sample got %0d want %0d (phase %0d)",
                                    out_data.sample, want.sample, want.phase));
        if (out_data.phase !== want.phase)
          report_mismatch($sformatf("phase got %0d want %0d",
                                    out_data.phase, want.phase));
        checked_count++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout with %0d samples outstanding", expected_samples.size());
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // table corners and the unused command
  task automatic test_table_writes();
    send_write(8'h00, 7'h00, 8'h00);
    send_write(8'hFF, 7'h7F, 8'hFF);
    send_write(8'h55, 7'h2A, 8'hAA);
    send_item(random_item(CMD_UNUSED));
  endtask

  // zero frequency (slowest period), tiny, the low row edge, and the top code
  task automatic test_frequency_edges();
    send_freq(16'd0);
    send_freq(16'd1);
    send_freq(16'(16 * F0_MIN_HZ));
    send_freq(16'(16 * F0_MIN_HZ + 1));
    send_freq(16'hFFFF);
  endtask

  // count past a short period under a long one, then shorten: next tick fires
  task automatic test_lowered_period();
    send_freq(16'd16000);
    repeat (16) send_tick();
    send_freq(16'hFFFF);
    send_tick();
  endtask

  // mostly ticks at fast tones; frequency changes, table loads and noise mixed in
  task automatic test_random_traffic();
    int n, pick;
    n = 0;
    while (n < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        send_tick();
      end else if (pick < 78) begin
        if ($urandom_range(0, 4) == 0) send_freq(16'($urandom));
        else send_freq(16'($urandom_range(24000, 65535)));
      end else if (pick < 88) begin
        // near the rows being played, so loads show up in later samples
        send_write(row_sel + 8'($urandom_range(0, 1)),
                   cursor_pos + 7'($urandom_range(0, 7)), 8'($urandom));
      end else if (pick < 98) begin
        send_write(8'($urandom), 7'($urandom), 8'($urandom));
      end else begin
        send_item(random_item(CMD_UNUSED));
      end
      n++;
    end
  endtask

  initial begin
    timer      = '0;
    period     = period_from_freq(16'd1760);  // 110 Hz after reset
    row_sel    = '0;
    blend_w    = '0;
    cursor_pos = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_table_writes();
    test_frequency_edges();
    test_lowered_period();
    test_random_traffic();

    in_valid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d transactions in (%0d frequency sets, %0d table loads), %0d samples checked",
             item_count, freq_count, write_count, checked_count);
    $display("%0d mismatches over %0d cycles", err_count, cycle_count);
    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
